// ===== rtl/core/tcr_pkg.sv =====
package tcr_pkg;

  // Input item kinds.
  localparam logic [2:0] KindWrStart = 3'd0;
  localparam logic [2:0] KindWrByte  = 3'd1;
  localparam logic [2:0] KindRdByte  = 3'd2;
  localparam logic [2:0] KindYMove   = 3'd3;
  localparam logic [2:0] KindXMove   = 3'd4;
  localparam logic [2:0] KindTouch   = 3'd5;

  // Bus addresses of the register window.
  localparam logic [15:0] WinBase    = 16'h8000;
  localparam logic [15:0] WinEnd     = 16'h8178;
  localparam logic [15:0] TouchAddr  = 16'h814E;
  localparam logic [15:0] WrLastOff  = 16'h0100;
  localparam logic [6:0]  WinPageHi  = 7'h40;   // pages 0x80 and 0x81

  // Writable part of the window is held in a memory.
  localparam int unsigned MemDepth = 257;
  localparam int unsigned OffW     = 9;

  // Window offsets.
  localparam logic [OffW-1:0] OffXmaxLo = 9'h048;
  localparam logic [OffW-1:0] OffXmaxHi = 9'h049;
  localparam logic [OffW-1:0] OffYmaxLo = 9'h04A;
  localparam logic [OffW-1:0] OffYmaxHi = 9'h04B;
  localparam logic [OffW-1:0] OffMode   = 9'h04D;
  localparam logic [OffW-1:0] OffTouch  = 9'h14E;
  localparam logic [OffW-1:0] OffPtXLo  = 9'h150;
  localparam logic [OffW-1:0] OffPtXHi  = 9'h151;
  localparam logic [OffW-1:0] OffPtYLo  = 9'h152;
  localparam logic [OffW-1:0] OffPtYHi  = 9'h153;
  localparam logic [OffW-1:0] OffMemLast = 9'h100;

  localparam logic [7:0] TouchReset = 8'h80;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         write_byte;
    logic signed [15:0] level;
  } tcr_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       fault;
  } tcr_out_t;

  // Event-driven updates of the registers above the writable area.
  typedef struct packed {
    logic        touch_we;
    logic [7:0]  touch;
    logic        pt_x_we;
    logic [15:0] pt_x;
    logic        pt_y_we;
    logic [15:0] pt_y;
  } tcr_upd_t;

endpackage

// ===== rtl/core/i2c_touch_controller_regs.sv =====
// Register map of a bus-attached touch panel controller.
//
// Items enter on the command port: a word on in_i is taken at a rising edge
// where start is high and busy is low. busy is always low, so a new word
// may be presented in every cycle; the block sustains one word per cycle.
// Each word gives exactly one result word on res_o, shown for one cycle
// with strobe_o high, in the cycle after the word was taken. The
// receiver cannot hold results off, so nothing is buffered.
//
// The writable window bytes (offsets 0x000..0x100) live in a single-port
// write, single-port read memory whose read data is registered; a valid
// flop per byte makes bytes not yet written read as zero. Touch status and
// the point 1 coordinates are flops, as are shadow copies of the X and Y
// maxima and of mode bit 7, which the cursor logic needs in the same cycle.
//
// Reset (rst_ni low, asynchronous) clears the pointer, the pending pointer
// byte count, both cursors and the valid flops, and sets touch status to
// 0x80. No clearing pass is needed, so words are accepted straight away.
module i2c_touch_controller_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tcr_pkg::tcr_in_t  in_i,
  output logic              strobe_o,
  output tcr_pkg::tcr_out_t res_o
);
  import tcr_pkg::*;

  logic        accept;
  logic [15:0] ptr_q, ptr_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  pend_dec;
  logic [15:0] off16;
  logic        wr_in_mem;
  logic        wr_touch;
  logic        page_ok;
  logic        in_win;

  logic        wr_en;
  logic        rd_en;
  logic        rd_hit_d, rd_hit_q;
  logic        fault_d, fault_q;
  logic        strobe_q;
  logic        x_en, y_en;
  tcr_upd_t    upd;

  logic [7:0]  rd_data;
  logic [15:0] xmax, ymax;
  logic        y_inv;
  logic [7:0]  touch;
  logic [15:0] cur_x_d, cur_y_d;

  // Every word is taken on its first cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Address decode of the current pointer.
  assign off16     = ptr_q - WinBase;
  assign wr_in_mem = (off16 <= WrLastOff);
  assign wr_touch  = (ptr_q == TouchAddr);
  assign page_ok   = (ptr_q[15:9] == WinPageHi);
  assign in_win    = (ptr_q < WinEnd);
  assign pend_dec  = pend_q - 2'd1;

  always_comb begin
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_hit_d     = 1'b0;
    fault_d      = 1'b0;
    x_en         = 1'b0;
    y_en         = 1'b0;
    upd.touch_we = 1'b0;
    upd.touch    = touch;
    upd.pt_x_we  = 1'b0;
    upd.pt_x     = cur_x_d;
    upd.pt_y_we  = 1'b0;
    upd.pt_y     = y_inv ? cur_y_d : (ymax - cur_y_d);
    if (accept) begin
      case (in_i.kind)
        KindWrStart: begin
          pend_d = 2'd2;
        end
        KindWrByte: begin
          if (pend_q != 2'd0) begin
            // Pointer load, high byte first.
            pend_d = pend_dec;
            if (pend_dec == 2'd1) begin
              ptr_d = {in_i.write_byte, ptr_q[7:0]};
            end else begin
              ptr_d = {ptr_q[15:8], in_i.write_byte};
            end
          end else if (wr_in_mem) begin
            wr_en = 1'b1;
            ptr_d = ptr_q + 16'd1;
          end else if (wr_touch) begin
            // Touch status keeps the pointer and forces buffer ready.
            upd.touch_we = 1'b1;
            upd.touch    = in_i.write_byte | 8'h80;
          end else begin
            fault_d = 1'b1;
          end
        end
        KindRdByte: begin
          if (page_ok) begin
            rd_en    = in_win;
            rd_hit_d = in_win;
            ptr_d    = ptr_q + 16'd1;
          end else begin
            fault_d = 1'b1;
          end
        end
        KindYMove: begin
          y_en        = 1'b1;
          upd.pt_y_we = 1'b1;
        end
        KindXMove: begin
          x_en        = 1'b1;
          upd.pt_x_we = 1'b1;
        end
        KindTouch: begin
          upd.touch_we = 1'b1;
          upd.touch    = (touch & 8'h70) | 8'h80 | {4'h0, in_i.level[3:0]};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= 16'h0000;
      pend_q   <= 2'd0;
      strobe_q <= 1'b0;
      rd_hit_q <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      strobe_q <= accept;
      rd_hit_q <= rd_hit_d;
      fault_q  <= fault_d;
    end
  end

  tcr_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_off_i  (off16[8:0]),
    .wr_data_i (in_i.write_byte),
    .rd_en_i   (rd_en),
    .rd_off_i  (ptr_q[8:0]),
    .upd_i     (upd),
    .rd_data_o (rd_data),
    .xmax_o    (xmax),
    .ymax_o    (ymax),
    .y_inv_o   (y_inv),
    .touch_o   (touch)
  );

  tcr_cursor u_cursor_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (x_en),
    .delta_i (in_i.level),
    .max_i   (xmax),
    .cur_d_o (cur_x_d)
  );

  tcr_cursor u_cursor_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (y_en),
    .delta_i (in_i.level),
    .max_i   (ymax),
    .cur_d_o (cur_y_d)
  );

  // Reads above the window and all non-read words return zero.
  assign strobe_o        = strobe_q;
  assign res_o.read_byte = rd_hit_q ? rd_data : 8'h00;
  assign res_o.fault     = fault_q;

endmodule

// ===== rtl/core/tcr_regfile.sv =====
module tcr_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [8:0]          wr_off_i,
  input  logic [7:0]          wr_data_i,
  input  logic                rd_en_i,
  input  logic [8:0]          rd_off_i,
  input  tcr_pkg::tcr_upd_t   upd_i,
  output logic [7:0]          rd_data_o,
  output logic [15:0]         xmax_o,
  output logic [15:0]         ymax_o,
  output logic                y_inv_o,
  output logic [7:0]          touch_o
);
  import tcr_pkg::*;

  logic [7:0]          mem [0:MemDepth-1];
  logic [MemDepth-1:0] valid_q;
  logic [7:0]          mem_rd_q;
  logic                mem_sel_q;
  logic                vld_q;
  logic [7:0]          small_q;
  logic [7:0]          small_d;
  logic                rd_in_mem;

  logic [15:0] xmax_q, ymax_q, pt_x_q, pt_y_q;
  logic        y_inv_q;
  logic [7:0]  touch_q;

  assign rd_in_mem = (rd_off_i <= OffMemLast);

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_off_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && rd_in_mem) begin
      mem_rd_q <= mem[rd_off_i];
    end
  end

  // Bytes above the writable area that are backed by flops.
  always_comb begin
    case (rd_off_i)
      OffTouch: small_d = touch_q;
      OffPtXLo: small_d = pt_x_q[7:0];
      OffPtXHi: small_d = pt_x_q[15:8];
      OffPtYLo: small_d = pt_y_q[7:0];
      OffPtYHi: small_d = pt_y_q[15:8];
      default:  small_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      mem_sel_q <= 1'b0;
      vld_q     <= 1'b0;
      small_q   <= 8'h00;
      xmax_q    <= 16'h0000;
      ymax_q    <= 16'h0000;
      y_inv_q   <= 1'b0;
      touch_q   <= TouchReset;
      pt_x_q    <= 16'h0000;
      pt_y_q    <= 16'h0000;
    end else begin
      if (rd_en_i) begin
        mem_sel_q <= rd_in_mem;
        vld_q     <= rd_in_mem && valid_q[rd_off_i];
        small_q   <= small_d;
      end
      if (wr_en_i) begin
        valid_q[wr_off_i] <= 1'b1;
        case (wr_off_i)
          OffXmaxLo: xmax_q[7:0]  <= wr_data_i;
          OffXmaxHi: xmax_q[15:8] <= wr_data_i;
          OffYmaxLo: ymax_q[7:0]  <= wr_data_i;
          OffYmaxHi: ymax_q[15:8] <= wr_data_i;
          OffMode:   y_inv_q      <= wr_data_i[7];
          default: ;
        endcase
      end
      if (upd_i.touch_we) begin
        touch_q <= upd_i.touch;
      end
      if (upd_i.pt_x_we) begin
        pt_x_q <= upd_i.pt_x;
      end
      if (upd_i.pt_y_we) begin
        pt_y_q <= upd_i.pt_y;
      end
    end
  end

  // A memory byte never written since reset reads as zero.
  assign rd_data_o = mem_sel_q ? (vld_q ? mem_rd_q : 8'h00) : small_q;
  assign xmax_o    = xmax_q;
  assign ymax_o    = ymax_q;
  assign y_inv_o   = y_inv_q;
  assign touch_o   = touch_q;

endmodule

// ===== rtl/core/tcr_cursor.sv =====
module tcr_cursor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [15:0] delta_i,
  input  logic [15:0]        max_i,
  output logic [15:0]        cur_d_o
);
  import tcr_pkg::*;

  logic [15:0]        cur_q;
  logic signed [17:0] sum;

  // The sum cannot wrap in 18 bits; clamp it to zero and to the maximum.
  assign sum = $signed({2'b00, cur_q}) + $signed({{2{delta_i[15]}}, delta_i});

  always_comb begin
    if (sum[17]) begin
      cur_d_o = 16'h0000;
    end else if (sum[16:0] > {1'b0, max_i}) begin
      cur_d_o = max_i;
    end else begin
      cur_d_o = sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 16'h0000;
    end else if (en_i) begin
      cur_q <= cur_d_o;
    end
  end

endmodule
